>>> hw/rtl/dimmer_ramp_controller_defines.svh
// Assertion macros for the dimmer ramp controller.
// Used by the top level only; no other dependencies.
`ifndef DIMMER_RAMP_CONTROLLER_DEFINES_SVH
`define DIMMER_RAMP_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define DRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define DRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DRC_ASSERT(lbl, clk, rstn, prop, msg)
`define DRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hw/rtl/drc_pkg.sv
// Shared codes and helpers for the dimmer ramp controller.
// No dependencies.
package drc_pkg;

    // command codes (s_tuser)
    localparam logic [2:0] FUNC_SET    = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_STOP   = 3'd2;
    localparam logic [2:0] FUNC_RAMP   = 3'd3;
    localparam logic [2:0] FUNC_TIME   = 3'd4;
    localparam logic [2:0] FUNC_STATUS = 3'd5;

    // event codes (m_tuser)
    localparam logic [2:0] EVT_NONE    = 3'd0;
    localparam logic [2:0] EVT_STARTED = 3'd1;
    localparam logic [2:0] EVT_ON      = 3'd2;
    localparam logic [2:0] EVT_OFF     = 3'd3;
    localparam logic [2:0] EVT_STATUS  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_START = 2'd0;
    localparam logic [1:0] CFG_RANGE_END   = 2'd1;
    localparam logic [1:0] CFG_STEP_NORMAL = 2'd2;
    localparam logic [1:0] CFG_STEP_START  = 2'd3;

    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam logic [9:0] LEVEL_MAX = 10'd1000;

    // x / 10 by reciprocal, exact for x up to 1019
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [17:0] prod;
        prod = {8'd0, x} * 18'd205;
        return prod[17:11];
    endfunction

    // x * 10 as two shifted adds
    function automatic logic [10:0] mul10(input logic [6:0] x);
        return {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
    endfunction

endpackage

>>> hw/rtl/dimmer_ramp_controller.sv
// Dimmer ramp controller top level.
// Depends on drc_pkg and dimmer_ramp_controller_defines.svh.
//
// Usage:
//   s_ channel carries commands and ticks: s_tuser holds the command code,
//   s_tdata the level, hold count and start mode. Every accepted item gives
//   exactly one result on the m_ channel: m_tuser is the event kind, m_tdata
//   the event percent, rising flag, drive update flag and drive level.
//   cfg_wr_en / cfg_index / cfg_wdata write the range and step registers;
//   write only while no item is in flight.
//   An accepted item is held in the input register; its result is then
//   loaded into the output register, whose valid flag drives m_tvalid.
//   Throughput is one item per cycle while the receiver takes results:
//   all state update is one combinational pass over the input register
//   and the state registers.
//   When the receiver stalls, the result holds, the input register fills and
//   s_tready falls; nothing is dropped. State only moves when a result is
//   loaded.
//   Reset (aresetn low, synchronous) clears both channels, sets the level,
//   goal and hold count to zero, the step to minus one and the
//   configuration registers to their defaults.
`include "dimmer_ramp_controller_defines.svh"

module dimmer_ramp_controller
    import drc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // level[6:0], hold_ticks[22:7], start_mode[24:23], zero
    input  logic [2:0]  s_tuser,  // func[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // event_percent[6:0], event_rising[7],
                                  // drive_update[8], drive_level[18:9], zero
    output logic [2:0]  m_tuser   // event_kind[2:0]
);

    // configuration
    logic [6:0] range_start_reg, range_end_reg;
    logic [9:0] step_normal_reg, step_start_reg;

    // state
    logic [9:0]         level_now_reg, level_now_next;
    logic [9:0]         level_goal_reg, level_goal_next;
    logic signed [10:0] signed_step_reg, signed_step_next;
    logic               ramping_reg, ramping_next;
    logic [15:0]        hold_left_reg, hold_left_next;

    // input register
    logic        s1_valid_reg;
    logic [2:0]  s1_func_reg;
    logic [6:0]  s1_level_reg;
    logic [15:0] s1_hold_reg;
    logic [1:0]  s1_mode_reg;

    // result register
    logic        m_valid_reg;
    logic [2:0]  kind_reg, kind_next;
    logic [6:0]  pct_reg, pct_next;
    logic        rising_reg, rising_next;
    logic        upd_reg, upd_next;
    logic [9:0]  drv_reg, drv_next;

    logic proc;

    assign proc     = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || proc;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {5'd0, drv_reg, upd_reg, rising_reg, pct_reg};

    // ramp start unit, shared by set, start and auto-off
    logic [6:0]         br_pct_raw, br_pct_a, br_pct;
    logic signed [10:0] br_base, br_s, br_step;
    logic [9:0]         br_mag, br_goal10, br_goal;
    logic [10:0]        br_goal11;
    logic               br_change;
    logic signed [10:0] eff_step;
    logic [6:0]         now_pct;

    assign now_pct  = div10(level_now_reg);
    assign eff_step = (s1_mode_reg == 2'd0) ? 11'sd1 : signed_step_reg;

    always_comb begin
        case (s1_func_reg)
            FUNC_START: begin
                br_pct_raw = (eff_step < 0) ? PCT_MAX : 7'd0;
                br_base    = eff_step;
                br_mag     = step_start_reg;
            end
            FUNC_TIME: begin
                br_pct_raw = 7'd0;
                br_base    = signed_step_reg;
                br_mag     = step_normal_reg;
            end
            default: begin
                br_pct_raw = s1_level_reg;
                br_base    = signed_step_reg;
                br_mag     = step_normal_reg;
            end
        endcase
        br_pct_a  = (br_pct_raw > PCT_MAX) ? PCT_MAX : br_pct_raw;
        br_pct    = (br_pct_a > range_end_reg) ? range_end_reg : br_pct_a;
        br_goal11 = mul10(br_pct);
        br_goal10 = br_goal11[9:0];
        br_s      = (br_mag == 10'd0) ? 11'sd1 : $signed({1'b0, br_mag});
        br_change = (br_pct != now_pct);
        br_goal   = br_change ? br_goal10 : level_goal_reg;
        if (br_change) begin
            br_step = (br_goal10 > level_now_reg) ? br_s : -br_s;
        end else begin
            br_step = br_base;
        end
    end

    // ramp tick arithmetic, 13-bit signed to hold lo/hi up to 1270 and now+step
    logic signed [12:0] now13, goal13, step13, lo13, hi13, up13, dn13;
    logic               go_up, go_down;

    assign now13   = $signed({3'b000, level_now_reg});
    assign goal13  = $signed({3'b000, level_goal_reg});
    assign step13  = {{2{signed_step_reg[10]}}, signed_step_reg};
    assign lo13    = $signed({2'b00, mul10(range_start_reg)});
    assign hi13    = $signed({2'b00, mul10(range_end_reg)});
    assign go_up   = (signed_step_reg > 0) && (level_now_reg < level_goal_reg);
    assign go_down = (signed_step_reg < 0) && (level_now_reg > level_goal_reg);

    always_comb begin
        logic signed [12:0] t_up, t_dn;
        t_up = (now13 < lo13) ? lo13 : now13 + step13;
        up13 = (t_up > goal13 || t_up > hi13) ? goal13 : t_up;
        t_dn = (now13 > hi13) ? hi13 : now13 + step13;
        dn13 = (t_dn < goal13 || t_dn < lo13) ? goal13 : t_dn;
    end

    always_comb begin
        level_now_next   = level_now_reg;
        level_goal_next  = level_goal_reg;
        signed_step_next = signed_step_reg;
        ramping_next     = ramping_reg;
        hold_left_next   = hold_left_reg;
        kind_next        = EVT_NONE;
        pct_next         = 7'd0;
        rising_next      = 1'b0;
        upd_next         = 1'b0;
        drv_next         = 10'd0;
        case (s1_func_reg) inside
            FUNC_SET, FUNC_START: begin
                hold_left_next   = (s1_func_reg == FUNC_SET) ? s1_hold_reg : 16'd0;
                level_goal_next  = br_goal;
                signed_step_next = br_step;
                ramping_next     = 1'b1;
                kind_next        = EVT_STARTED;
                rising_next      = (br_step > 0);
            end
            FUNC_STOP: begin
                hold_left_next = 16'd0;
                ramping_next   = 1'b0;
                if (level_now_reg != 10'd0) begin
                    kind_next = EVT_ON;
                    pct_next  = now_pct;
                end else begin
                    kind_next = EVT_OFF;
                end
            end
            FUNC_RAMP: begin
                if (ramping_reg) begin
                    upd_next = 1'b1;
                    if (go_up) begin
                        level_now_next = up13[9:0];
                        drv_next       = up13[9:0];
                    end else if (go_down) begin
                        level_now_next = dn13[9:0];
                        drv_next       = dn13[9:0];
                    end else begin
                        // arrived: settle on the goal and report on/off
                        level_now_next = level_goal_reg;
                        ramping_next   = 1'b0;
                        drv_next       = level_goal_reg;
                        if (level_goal_reg != 10'd0) begin
                            kind_next = EVT_ON;
                            pct_next  = div10(level_goal_reg);
                        end else begin
                            kind_next = EVT_OFF;
                        end
                    end
                end
            end
            FUNC_TIME: begin
                if (!ramping_reg && hold_left_reg != 16'd0) begin
                    hold_left_next = hold_left_reg - 16'd1;
                    // hold expired: silent ramp to dark
                    if (hold_left_reg == 16'd1) begin
                        level_goal_next  = br_goal;
                        signed_step_next = br_step;
                        ramping_next     = 1'b1;
                    end
                end
            end
            FUNC_STATUS: begin
                kind_next = EVT_STATUS;
                pct_next  = now_pct;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= 7'd0;
            range_end_reg   <= PCT_MAX;
            step_normal_reg <= 10'd10;
            step_start_reg  <= 10'd5;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RANGE_START: range_start_reg <= cfg_wdata[6:0];
                CFG_RANGE_END:   range_end_reg   <= cfg_wdata[6:0];
                CFG_STEP_NORMAL: step_normal_reg <= cfg_wdata;
                CFG_STEP_START:  step_start_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_now_reg   <= 10'd0;
            level_goal_reg  <= 10'd0;
            signed_step_reg <= -11'sd1;
            ramping_reg     <= 1'b0;
            hold_left_reg   <= 16'd0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (proc) begin
                level_now_reg   <= level_now_next;
                level_goal_reg  <= level_goal_next;
                signed_step_reg <= signed_step_next;
                ramping_reg     <= ramping_next;
                hold_left_reg   <= hold_left_next;
                m_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_func_reg  <= s_tuser;
            s1_level_reg <= s_tdata[6:0];
            s1_hold_reg  <= s_tdata[22:7];
            s1_mode_reg  <= s_tdata[24:23];
        end
        if (proc) begin
            kind_reg   <= kind_next;
            pct_reg    <= pct_next;
            rising_reg <= rising_next;
            upd_reg    <= upd_next;
            drv_reg    <= drv_next;
        end
    end

    `DRC_ASSERT(a_level_range, aclk, aresetn, level_now_reg <= LEVEL_MAX, "level out of range")
    `DRC_ASSERT(a_step_nonzero, aclk, aresetn, signed_step_reg != 11'sd0, "zero ramp step")
    `DRC_ASSERT(a_drive_matches, aclk, aresetn, !(m_valid_reg && upd_reg) || drv_reg == level_now_reg, "drive level differs from held level")
    `DRC_ASSERT_NEXT(a_done_idle, aclk, aresetn, proc && s1_func_reg == FUNC_RAMP && ramping_reg && !go_up && !go_down, !ramping_reg && level_now_reg == level_goal_reg, "ramp end did not settle")

endmodule
